// ----- design/ptw_pkg.sv -----
// Shared constants, payload types and memory request type of the page table walker.
`timescale 1ns / 1ps
package ptw_pkg;

   // Byte memory size (a power of two) and the widths that follow from it
   localparam int MEM_BYTES = 8192;
   localparam int ADDR_W    = $clog2(MEM_BYTES);
   localparam int BANKS     = 4;
   localparam int ROWS      = MEM_BYTES / BANKS;
   localparam int ROW_W     = ADDR_W - 2;

   // Fixed field widths
   localparam int TBL_BASE_W = 12;
   localparam int TBL_SUM_W  = 13;
   localparam int VA_W       = 14;
   localparam int PA_W       = 12;
   localparam int WORD_W     = 32;
   localparam int LOAD_ADR_W = 13;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Item modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_XLATE = 1'b1;

   // Register index (paddr word bit)
   localparam logic CSR_IDX_TABLE_BASE = 1'b0;

   typedef logic [ADDR_W-1:0]     byte_addr_type;
   typedef logic [ROW_W-1:0]      row_addr_type;
   typedef logic [TBL_SUM_W-1:0]  tbl_sum_type;
   typedef logic [TBL_BASE_W-1:0] tbl_base_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   typedef struct packed {
      logic                  mode;
      logic [LOAD_ADR_W-1:0] load_addr;
      logic [7:0]            load_byte;
      logic [VA_W-1:0]       virtual_addr;
   } req_item_type;

   typedef struct packed {
      logic              outer_valid;
      logic              inner_valid;
      logic [PA_W-1:0]   phys_addr;
      logic [WORD_W-1:0] data_word;
   } rsp_item_type;

   typedef struct packed {
      logic          rd_en;
      byte_addr_type rd_addr;
      logic          wr_en;
      byte_addr_type wr_addr;
      logic [7:0]    wr_byte;
   } mem_req_type;

endpackage

// ----- design/ptw_mem.sv -----
// Four-bank byte memory with word reads at any byte address and a clear pass after reset.
`timescale 1ns / 1ps
module ptw_mem (
   input  logic                           clock,
   input  logic                           reset,
   input  ptw_pkg::mem_req_type           mem_req,
   output logic                           mem_busy,
   output logic [ptw_pkg::WORD_W-1:0]     mem_word
);

   logic                  clr_busy_ff, clr_busy_in;
   ptw_pkg::row_addr_type clr_cnt_ff, clr_cnt_in;
   logic [1:0]            rd_lane_ff;
   logic [7:0]            bank_data [ptw_pkg::BANKS];

   // Sweep one row of all banks per cycle until the last row is zero
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == ptw_pkg::row_addr_type'(ptw_pkg::ROWS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   assign mem_busy = clr_busy_ff;

   // Remember which bank holds the first byte of the word being read
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_lane_ff <= mem_req.rd_addr[1:0];
      end
   end

   for (genvar k = 0; k < ptw_pkg::BANKS; k++) begin : g_bank
      logic [7:0]             mem_array [ptw_pkg::ROWS];
      logic [7:0]             rdata_ff;
      logic [1:0]             lane_off;
      ptw_pkg::byte_addr_type rd_byte;
      ptw_pkg::row_addr_type  rd_row;
      logic                   wr_hit;

      // Byte of the word that falls into this bank, with wrap at the top
      assign lane_off = 2'(k) - mem_req.rd_addr[1:0];
      assign rd_byte  = mem_req.rd_addr + ptw_pkg::byte_addr_type'(lane_off);
      assign rd_row   = rd_byte[ptw_pkg::ADDR_W-1:2];
      assign wr_hit   = mem_req.wr_en && (mem_req.wr_addr[1:0] == 2'(k));

      always_ff @(posedge clock) begin
         if (clr_busy_ff) begin
            mem_array[clr_cnt_ff] <= '0;
         end else if (wr_hit) begin
            mem_array[mem_req.wr_addr[ptw_pkg::ADDR_W-1:2]] <= mem_req.wr_byte;
         end
         if (mem_req.rd_en) begin
            rdata_ff <= mem_array[rd_row];
         end
      end

      assign bank_data[k] = rdata_ff;
   end

   // Assemble the word, first byte most significant
   always_comb begin
      logic [1:0] sel;
      sel      = '0;
      mem_word = '0;
      for (int i = 0; i < ptw_pkg::BANKS; i++) begin
         sel = rd_lane_ff + 2'(i);
         mem_word[ptw_pkg::WORD_W-1-8*i -: 8] = bank_data[sel];
      end
   end

endmodule

// ----- design/ptw_walk.sv -----
// Walk sequencer: issues the table and data reads, checks entries and holds the result.
`timescale 1ns / 1ps
module ptw_walk (
   input  logic                          clock,
   input  logic                          reset,
   input  ptw_pkg::tbl_base_type         table_base,
   input  logic                          req_valid,
   input  ptw_pkg::req_item_type         req_item,
   output logic                          req_stall,
   output logic                          rsp_valid,
   output ptw_pkg::rsp_item_type         rsp_item,
   input  logic                          rsp_stall,
   output ptw_pkg::mem_req_type          mem_req,
   input  logic                          mem_busy,
   input  logic [ptw_pkg::WORD_W-1:0]    mem_word
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_OUTER = 4'b0010,
      ST_INNER = 4'b0100,
      ST_DATA  = 4'b1000
   } walk_state_type;

   walk_state_type              state_ff, state_in;
   logic [ptw_pkg::VA_W-1:0]    va_ff, va_in;
   logic [ptw_pkg::PA_W-1:0]    pa_ff, pa_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ptw_pkg::rsp_item_type       rsp_item_ff, rsp_item_in;
   ptw_pkg::rsp_item_type       result;
   ptw_pkg::tbl_sum_type        outer_sum, inner_sum;
   logic [ptw_pkg::PA_W-1:0]    pa_next;
   logic                        accept, finish, slot_free;

   assign req_stall = (state_ff != ST_IDLE) || mem_busy;
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Entry addresses: outer from the base, inner from the outer entry
   assign outer_sum = ptw_pkg::tbl_sum_type'(table_base)
                    + ptw_pkg::tbl_sum_type'({req_item.virtual_addr[13:10], 2'b00});
   assign inner_sum = ptw_pkg::tbl_sum_type'(mem_word[31:20])
                    + ptw_pkg::tbl_sum_type'({va_ff[9:6], 2'b00});
   assign pa_next   = {mem_word[31:26], va_ff[5:0]};

   // Advance the walk one dependent read per cycle
   always_comb begin
      state_in = state_ff;
      va_in    = va_ff;
      pa_in    = pa_ff;
      mem_req  = '0;
      finish   = 1'b0;
      result   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.mode == ptw_pkg::MODE_LOAD) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = ptw_pkg::byte_addr_type'(req_item.load_addr);
                  mem_req.wr_byte = req_item.load_byte;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = ptw_pkg::byte_addr_type'(outer_sum);
                  va_in           = req_item.virtual_addr;
                  state_in        = ST_OUTER;
               end
            end
         end
         ST_OUTER: begin
            if (!mem_word[0]) begin
               finish = 1'b1;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ptw_pkg::byte_addr_type'(inner_sum);
               state_in        = ST_INNER;
            end
         end
         ST_INNER: begin
            if (!mem_word[0]) begin
               finish             = 1'b1;
               result.outer_valid = 1'b1;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ptw_pkg::byte_addr_type'(pa_next);
               pa_in           = pa_next;
               state_in        = ST_DATA;
            end
         end
         ST_DATA: begin
            finish             = 1'b1;
            result.outer_valid = 1'b1;
            result.inner_valid = 1'b1;
            result.phys_addr   = pa_ff;
            result.data_word   = mem_word;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Hold in the last state while the output slot is occupied
      if (finish && slot_free) begin
         state_in = ST_IDLE;
      end
   end

   // Output register: load on finish, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (finish && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff       <= va_in;
      pa_ff       <= pa_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- design/two_level_page_table_walker_top.sv -----
// Top level of the two-level page table walker: register port, walker and byte memory.
//
//  channel | direction | handshake                        | payload
//  req_    | in        | req_valid / req_stall            | ptw_pkg::req_item_type
//  rsp_    | out       | rsp_valid / rsp_stall            | ptw_pkg::rsp_item_type
//  csr_    | in / out  | psel, penable, pwrite, pready=1  | table_base at byte address 0
//
// A load item writes its byte when it is accepted. A translate item finishes on the outer read
// on an outer fault, on the inner read on an inner fault and otherwise on the data word read;
// each step issues one dependent word read, served by the four byte banks from a register.
// After reset the byte memory is cleared one row of four bytes a cycle, MEM_BYTES/4 rows
// (2048 at 8192 bytes); req_stall stays high during that pass.
// A finished walk waits in its last state while rsp_stall holds the previous result.
`timescale 1ns / 1ps
module two_level_page_table_walker_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  ptw_pkg::req_item_type             req_item,
   output logic                              req_stall,
   output logic                              rsp_valid,
   output ptw_pkg::rsp_item_type             rsp_item,
   input  logic                              rsp_stall,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ptw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ptw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   ptw_pkg::tbl_base_type          table_base_ff, table_base_in;
   ptw_pkg::mem_req_type           mem_req;
   logic                           mem_busy;
   logic [ptw_pkg::WORD_W-1:0]     mem_word;
   logic                           csr_hit;

   // Register port: write table_base on the access cycle
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == ptw_pkg::CSR_IDX_TABLE_BASE);

   always_comb begin
      table_base_in = table_base_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         table_base_in = csr_pwdata[ptw_pkg::TBL_BASE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_base_ff <= '0;
      end else begin
         table_base_ff <= table_base_in;
      end
   end

   assign csr_prdata = csr_hit ? ptw_pkg::csr_data_type'(table_base_ff) : '0;

   ptw_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .table_base (table_base_ff),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .rsp_stall  (rsp_stall),
      .mem_req    (mem_req),
      .mem_busy   (mem_busy),
      .mem_word   (mem_word)
   );

   ptw_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .mem_req  (mem_req),
      .mem_busy (mem_busy),
      .mem_word (mem_word)
   );

   // No item enters while the clear pass runs
   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      mem_busy |-> req_stall)
      else $error("item accepted during memory clear");

   // A translate item occupies the walker for at least the next cycle
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_item.mode == ptw_pkg::MODE_XLATE)) |=> req_stall)
      else $error("walker accepted an item right after a translate item");

   // A valid inner entry implies a valid outer entry
   a_inner_needs_outer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.outer_valid || !rsp_item.inner_valid))
      else $error("inner_valid set without outer_valid");

   // Faulted walks report zero address and data
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.inner_valid) |->
         ((rsp_item.phys_addr == '0) && (rsp_item.data_word == '0)))
      else $error("faulted walk carries address or data");

endmodule
